// ===== hw/rtl/tpra_pkg.sv =====
`default_nettype none
package tpra_pkg;

  localparam int LANES = 3;
  localparam int RES_W = 30;
  localparam int OUT_W = 63;
  localparam int INT_W = 64;
  localparam int BAR_W = INT_W - RES_W + 1;
  localparam int STEPS = RES_W;
  localparam int RED_LAT = 3;
  localparam int MM_LAT = RED_LAT + 1;
  localparam int RCN_LAT = 17;
  localparam int QUEUE_DEPTH = 2;
  localparam int OUT_DEPTH = 2;

  localparam logic [RES_W-1:0] P0 = 30'd1000000007;
  localparam logic [RES_W-1:0] P1 = 30'd998244353;
  localparam logic [RES_W-1:0] P2 = 30'd999999937;

  localparam logic [LANES-1:0][RES_W-1:0] LANE_P = {P2, P1, P0};
  localparam logic [LANES-1:0][RES_W-1:0] LANE_E = {P2 - 30'd2, P1 - 30'd2, P0 - 30'd2};
  localparam logic [LANES-1:0][BAR_W-1:0] LANE_M = {
    BAR_W'(64'hFFFF_FFFF_FFFF_FFFF / 64'(P2)),
    BAR_W'(64'hFFFF_FFFF_FFFF_FFFF / 64'(P1)),
    BAR_W'(64'hFFFF_FFFF_FFFF_FFFF / 64'(P0))
  };

  localparam logic [63:0] P01 = 64'(P0) * 64'(P1);
  localparam logic [RES_W-1:0] P01_LO = P01[RES_W-1:0];
  localparam logic [RES_W-1:0] P01_HI = P01[2*RES_W-1:RES_W];
  localparam logic [RES_W-1:0] C02 = P0 - P2;

  typedef enum logic [2:0] {
    KIND_CONVERT = 3'd0,
    KIND_ADD     = 3'd1,
    KIND_SUB     = 3'd2,
    KIND_MUL     = 3'd3,
    KIND_DIV     = 3'd4,
    KIND_RECON   = 3'd5
  } kind_e;

  typedef struct packed {
    logic [2:0]             kind;
    logic signed [INT_W-1:0] int_value;
    logic [RES_W-1:0]       a0;
    logic [RES_W-1:0]       a1;
    logic [RES_W-1:0]       a2;
    logic [RES_W-1:0]       b0;
    logic [RES_W-1:0]       b1;
    logic [RES_W-1:0]       b2;
  } in_t;

  typedef struct packed {
    logic [RES_W-1:0] r0;
    logic [RES_W-1:0] r1;
    logic [RES_W-1:0] r2;
    logic [OUT_W-1:0] recon_value;
  } out_t;

  typedef struct packed {
    logic [2:0]                   kind;
    logic                         neg;
    logic [INT_W-1:0]             mag;
    logic [LANES-1:0][RES_W-1:0]  a;
    logic [LANES-1:0][RES_W-1:0]  b;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } qhead_t;

  function automatic logic [RES_W-1:0] red30(logic [RES_W-1:0] x, logic [RES_W-1:0] p);
    return (x >= p) ? x - p : x;
  endfunction

  function automatic logic [RES_W-1:0] sub_mod(logic [RES_W-1:0] x, logic [RES_W-1:0] y,
                                               logic [RES_W-1:0] p);
    return (x >= y) ? x - y : RES_W'(31'(x) + 31'(p) - 31'(y));
  endfunction

  function automatic logic [RES_W-1:0] mul_mod_c(logic [RES_W-1:0] x, logic [RES_W-1:0] y,
                                                 logic [RES_W-1:0] p);
    logic [RES_W:0] acc;
    logic [RES_W:0] xx;
    acc = '0;
    xx = {1'b0, x};
    for (int i = 0; i < RES_W; i++) begin
      if (y[i]) begin
        acc = acc + xx;
        if (acc >= {1'b0, p}) acc = acc - {1'b0, p};
      end
      xx = xx + xx;
      if (xx >= {1'b0, p}) xx = xx - {1'b0, p};
    end
    return acc[RES_W-1:0];
  endfunction

  function automatic logic [RES_W-1:0] inv_mod(logic [RES_W-1:0] x, logic [RES_W-1:0] p);
    logic [RES_W-1:0] acc;
    logic [RES_W-1:0] base;
    logic [RES_W-1:0] e;
    acc = RES_W'(1);
    base = x;
    e = p - RES_W'(2);
    for (int i = 0; i < RES_W; i++) begin
      if (e[i]) acc = mul_mod_c(acc, base, p);
      base = mul_mod_c(base, base, p);
    end
    return acc;
  endfunction

  localparam logic [RES_W-1:0] INV1 = inv_mod(P0 - P1, P1);
  localparam logic [RES_W-1:0] INV2 = inv_mod(RES_W'(P01 % 64'(P2)), P2);

endpackage
`default_nettype wire

// ===== hw/rtl/tpra_reduce.sv =====
`default_nettype none
module tpra_reduce import tpra_pkg::*; (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [INT_W-1:0] x_i,
  input  logic [RES_W-1:0] p_i,
  input  logic [BAR_W-1:0] m_i,
  output logic [RES_W-1:0] r_o
);

  localparam int SH = RES_W - 1;

  logic [2*BAR_W-1:0] t;
  logic [31:0]        q_q;
  logic [31:0]        xlo_q;
  logic [61:0]        qp;
  logic [31:0]        r_q;
  logic [31:0]        p1;
  logic [31:0]        p2;
  logic [31:0]        p3;
  logic [RES_W-1:0]   out_q;

  assign t  = (2*BAR_W)'(x_i[INT_W-1:SH]) * (2*BAR_W)'(m_i);
  assign qp = 62'(q_q) * 62'(p_i);
  assign p1 = 32'(p_i);
  assign p2 = p1 << 1;
  assign p3 = p2 + p1;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q_q   <= t[BAR_W+31:BAR_W];
      xlo_q <= x_i[31:0];
      r_q   <= xlo_q - qp[31:0];
      if (r_q >= p3) begin
        out_q <= RES_W'(r_q - p3);
      end else if (r_q >= p2) begin
        out_q <= RES_W'(r_q - p2);
      end else if (r_q >= p1) begin
        out_q <= RES_W'(r_q - p1);
      end else begin
        out_q <= RES_W'(r_q);
      end
    end
  end

  assign r_o = out_q;

endmodule
`default_nettype wire

// ===== hw/rtl/tpra_modmul.sv =====
`default_nettype none
module tpra_modmul import tpra_pkg::*; (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [RES_W-1:0] a_i,
  input  logic [RES_W-1:0] b_i,
  input  logic [RES_W-1:0] p_i,
  input  logic [BAR_W-1:0] m_i,
  output logic [RES_W-1:0] r_o
);

  logic [2*RES_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= (2*RES_W)'(a_i) * (2*RES_W)'(b_i);
    end
  end

  tpra_reduce u_red (
    .clk_i (clk_i),
    .en_i  (en_i),
    .x_i   (INT_W'(prod_q)),
    .p_i   (p_i),
    .m_i   (m_i),
    .r_o   (r_o)
  );

endmodule
`default_nettype wire

// ===== hw/rtl/tpra_front.sv =====
`default_nettype none
module tpra_front import tpra_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  in_t    in_data_i,
  output logic   full_o,
  output qhead_t q_o,
  input  logic   q_pop_i
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t            item;
  item_t            mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_q;
  logic [PTR_W-1:0] rd_q;
  logic [CNT_W-1:0] cnt_q;
  logic             wr_en;
  logic             rd_en;
  logic [INT_W-1:0] ival;

  assign ival = in_data_i.int_value;

  always_comb begin
    item.kind = in_data_i.kind;
    item.neg  = ival[INT_W-1];
    item.mag  = item.neg ? (~ival + INT_W'(1)) : ival;
    item.a[0] = red30(in_data_i.a0, P0);
    item.a[1] = red30(in_data_i.a1, P1);
    item.a[2] = red30(in_data_i.a2, P2);
    item.b[0] = red30(in_data_i.b0, P0);
    item.b[1] = red30(in_data_i.b1, P1);
    item.b[2] = red30(in_data_i.b2, P2);
  end

  assign full_o   = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign wr_en    = push_i && !full_o;
  assign rd_en    = q_pop_i && (cnt_q != '0);
  assign q_o.valid = (cnt_q != '0);
  assign q_o.item  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_q] <= item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr_en) begin
        wr_q <= (wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
      end
      if (rd_en) begin
        rd_q <= (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
      end
      cnt_q <= cnt_q + CNT_W'(wr_en) - CNT_W'(rd_en);
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/tpra_back.sv =====
`default_nettype none
module tpra_back import tpra_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  qhead_t q_i,
  output logic   q_pop_o,
  output logic   empty_o,
  output out_t   out_data_o,
  input  logic   pop_i
);

  localparam int FIN  = MM_LAT * STEPS;
  localparam int POST = FIN + 1 + RED_LAT;
  localparam int LAST = POST + 1;
  localparam int RB   = LAST - RCN_LAT;
  localparam int PTR_W = $clog2(OUT_DEPTH);
  localparam int CNT_W = $clog2(OUT_DEPTH + 1);

  logic             en;
  item_t            meta_q [LAST+1];
  logic [LAST:0]    vld_q;

  logic [RES_W-1:0] acc_w  [LANES][STEPS+1];
  logic [RES_W-1:0] base_w [LANES][STEPS];

  logic [INT_W-1:0] prod_q [LANES];
  logic [RES_W-1:0] red_r  [LANES];
  logic [RES_W-1:0] res_d  [LANES];
  logic [RES_W-1:0] res_q  [LANES];

  // reconstruct chain
  logic [RES_W-1:0]   d1_q;
  logic [RES_W-1:0]   v1;
  logic [RES_W-1:0]   u;
  logic [RES_W-1:0]   d2_q;
  logic [RES_W-1:0]   v2;
  logic [2*RES_W-1:0] v1p0_q;
  logic [2*RES_W-1:0] w_q [9];
  logic [2*RES_W-1:0] plo_q;
  logic [2*RES_W-1:0] phi_q;
  logic [OUT_W-1:0]   ph63;
  logic [OUT_W-1:0]   rot;
  logic [INT_W-1:0]   s;
  logic [INT_W-1:0]   f_q;
  logic [OUT_W-1:0]   g;
  logic [OUT_W-1:0]   g_q;

  out_t             out_w;
  out_t             of_mem_q [OUT_DEPTH];
  logic [PTR_W-1:0] of_wr_q;
  logic [PTR_W-1:0] of_rd_q;
  logic [CNT_W-1:0] of_cnt_q;
  logic             of_full;
  logic             of_push;
  logic             of_pop;

  assign of_full = (of_cnt_q == CNT_W'(OUT_DEPTH));
  assign en      = !(vld_q[LAST] && of_full);
  assign q_pop_o = en && q_i.valid;

  always_ff @(posedge clk_i) begin
    if (en) begin
      meta_q[0] <= q_i.item;
      for (int i = 1; i <= LAST; i++) begin
        meta_q[i] <= meta_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAST-1:0], q_i.valid};
    end
  end

  // Fermat inverse ladder, square and multiply per exponent bit
  for (genvar l = 0; l < LANES; l++) begin : gen_lane
    assign acc_w[l][0]  = RES_W'(1);
    assign base_w[l][0] = meta_q[0].b[l];
    for (genvar k = 0; k < STEPS; k++) begin : gen_step
      tpra_modmul u_acc (
        .clk_i (clk_i),
        .en_i  (en),
        .a_i   (acc_w[l][k]),
        .b_i   (LANE_E[l][k] ? base_w[l][k] : RES_W'(1)),
        .p_i   (LANE_P[l]),
        .m_i   (LANE_M[l]),
        .r_o   (acc_w[l][k+1])
      );
      if (k < STEPS - 1) begin : gen_sq
        tpra_modmul u_sq (
          .clk_i (clk_i),
          .en_i  (en),
          .a_i   (base_w[l][k]),
          .b_i   (base_w[l][k]),
          .p_i   (LANE_P[l]),
          .m_i   (LANE_M[l]),
          .r_o   (base_w[l][k+1])
        );
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        if (meta_q[FIN].kind == KIND_CONVERT) begin
          prod_q[l] <= meta_q[FIN].mag;
        end else begin
          prod_q[l] <= INT_W'((2*RES_W)'(meta_q[FIN].a[l]) *
                       (2*RES_W)'((meta_q[FIN].kind == KIND_DIV) ? acc_w[l][STEPS]
                                                                 : meta_q[FIN].b[l]));
        end
      end
    end

    tpra_reduce u_fin (
      .clk_i (clk_i),
      .en_i  (en),
      .x_i   (prod_q[l]),
      .p_i   (LANE_P[l]),
      .m_i   (LANE_M[l]),
      .r_o   (red_r[l])
    );
  end

  always_comb begin
    logic [RES_W-1:0] m;
    logic [RES_W-1:0] p;
    logic [RES_W-1:0] a;
    logic [RES_W-1:0] b;
    logic [RES_W:0]   sum;
    for (int l = 0; l < LANES; l++) begin
      m   = red_r[l];
      p   = LANE_P[l];
      a   = meta_q[POST].a[l];
      b   = meta_q[POST].b[l];
      sum = (RES_W+1)'(a) + (RES_W+1)'(b);
      unique case (meta_q[POST].kind)
        KIND_CONVERT: res_d[l] = (meta_q[POST].neg && m != '0) ? p - m : m;
        KIND_ADD:     res_d[l] = (sum >= (RES_W+1)'(p)) ? RES_W'(sum - (RES_W+1)'(p))
                                                        : sum[RES_W-1:0];
        KIND_SUB:     res_d[l] = sub_mod(a, b, p);
        KIND_MUL,
        KIND_DIV:     res_d[l] = m;
        default:      res_d[l] = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < LANES; l++) begin
        res_q[l] <= res_d[l];
      end
    end
  end

  // Garner: v1, v1*P0 mod P2, v2, then fold into 2^63-1
  tpra_modmul u_v1 (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   (d1_q),
    .b_i   (INV1),
    .p_i   (P1),
    .m_i   (LANE_M[1]),
    .r_o   (v1)
  );

  tpra_modmul u_u (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   (v1),
    .b_i   (C02),
    .p_i   (P2),
    .m_i   (LANE_M[2]),
    .r_o   (u)
  );

  tpra_modmul u_v2 (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   (d2_q),
    .b_i   (INV2),
    .p_i   (P2),
    .m_i   (LANE_M[2]),
    .r_o   (v2)
  );

  assign ph63 = OUT_W'(phi_q);
  assign rot  = {ph63[OUT_W-RES_W-1:0], ph63[OUT_W-1:OUT_W-RES_W]};
  assign s    = INT_W'(w_q[8]) + INT_W'(plo_q) + INT_W'(rot);
  assign g    = f_q[OUT_W-1:0] + OUT_W'(f_q[INT_W-1]);

  always_ff @(posedge clk_i) begin
    if (en) begin
      d1_q   <= sub_mod(meta_q[RB].a[1], red30(meta_q[RB].a[0], P1), P1);
      v1p0_q <= (2*RES_W)'(v1) * (2*RES_W)'(P0);
      w_q[0] <= v1p0_q + (2*RES_W)'(meta_q[RB+6].a[0]);
      for (int i = 1; i < 9; i++) begin
        w_q[i] <= w_q[i-1];
      end
      d2_q   <= sub_mod(sub_mod(meta_q[RB+9].a[2], red30(meta_q[RB+9].a[0], P2), P2),
                        u, P2);
      plo_q  <= (2*RES_W)'(v2) * (2*RES_W)'(P01_LO);
      phi_q  <= (2*RES_W)'(v2) * (2*RES_W)'(P01_HI);
      f_q    <= INT_W'(s[OUT_W-1:0]) + INT_W'(s[INT_W-1]);
      g_q    <= (g == '1) ? '0 : g;
    end
  end

  // output queue
  always_comb begin
    out_w.r0 = res_q[0];
    out_w.r1 = res_q[1];
    out_w.r2 = res_q[2];
    out_w.recon_value = (meta_q[LAST].kind == KIND_RECON) ? g_q : '0;
  end

  assign of_push    = en && vld_q[LAST];
  assign of_pop     = pop_i && (of_cnt_q != '0);
  assign empty_o    = (of_cnt_q == '0);
  assign out_data_o = of_mem_q[of_rd_q];

  always_ff @(posedge clk_i) begin
    if (of_push) begin
      of_mem_q[of_wr_q] <= out_w;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      of_wr_q  <= '0;
      of_rd_q  <= '0;
      of_cnt_q <= '0;
    end else begin
      if (of_push) begin
        of_wr_q <= (of_wr_q == PTR_W'(OUT_DEPTH - 1)) ? '0 : of_wr_q + PTR_W'(1);
      end
      if (of_pop) begin
        of_rd_q <= (of_rd_q == PTR_W'(OUT_DEPTH - 1)) ? '0 : of_rd_q + PTR_W'(1);
      end
      of_cnt_q <= of_cnt_q + CNT_W'(of_push) - CNT_W'(of_pop);
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/three_prime_residue_alu_core.sv =====
`default_nettype none
// Residue ALU over the primes 1000000007, 998244353 and 999999937: convert, add,
// subtract, multiply, divide (by Fermat inverse, zero divisor gives zero) and
// Garner reconstruction modulo 2^63-1. One item is taken per cycle while the result
// side keeps popping; every item flows through the same fixed-depth pipeline,
// whose length is set by the 30-step exponent ladder of four-stage Barrett
// multipliers per lane. A two-entry queue sits between the input stage and the
// pipeline and another on the result side, so full rises only when results are
// not being taken.
module three_prime_residue_alu_core import tpra_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push,
  output logic full,
  input  in_t  in_data_i,
  output logic empty,
  input  logic pop,
  output out_t out_data_o
);

  qhead_t q_head;
  logic   q_pop;

  tpra_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .in_data_i (in_data_i),
    .full_o    (full),
    .q_o       (q_head),
    .q_pop_i   (q_pop)
  );

  tpra_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_i        (q_head),
    .q_pop_o    (q_pop),
    .empty_o    (empty),
    .out_data_o (out_data_o),
    .pop_i      (pop)
  );

endmodule
`default_nettype wire

// ===== hw/rtl/tpra_checker.sv =====
`default_nettype none
module tpra_checker import tpra_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic full,
  input logic empty,
  input logic pop,
  input out_t out_data_o
);

  assert property (@(posedge clk_i) !rst_ni |-> (empty && !full))
    else $error("queues not clear in reset");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_data_o)))
    else $error("waiting result changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (out_data_o.r0 < P0 && out_data_o.r1 < P1 && out_data_o.r2 < P2))
    else $error("residue out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (out_data_o.recon_value == '0 ||
                (out_data_o.r0 == '0 && out_data_o.r1 == '0 && out_data_o.r2 == '0 &&
                 out_data_o.recon_value != '1)))
    else $error("bad reconstruct transfer");

endmodule

bind three_prime_residue_alu_core tpra_checker u_chk (.*);
`default_nettype wire

// ===== dv/tb_three_prime_residue_alu_core.sv =====
`timescale 1ns / 1ps
module tb_three_prime_residue_alu_core;
  import tpra_pkg::*;

  localparam longint unsigned MOD63 = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam int LATENCY = 127;

  logic clk_i;
  logic rst_ni;
  logic push;
  logic full;
  in_t  in_data_i;
  logic empty;
  logic pop;
  out_t out_data_o;

  out_t expected_q[$];
  int   errors = 0;
  bit   pop_idle_en = 1'b1;
  bit   push_idle_en = 1'b1;

  three_prime_residue_alu_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_data_i  (in_data_i),
    .empty      (empty),
    .pop        (pop),
    .out_data_o (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic longint unsigned lane_prime(int l);
    return (l == 0) ? 64'd1000000007 : (l == 1) ? 64'd998244353 : 64'd999999937;
  endfunction

  function automatic longint unsigned power_mod(longint unsigned base, longint unsigned e,
                                                longint unsigned p);
    longint unsigned acc;
    acc = 1;
    base = base % p;
    while (e != 0) begin
      if (e[0]) acc = acc * base % p;
      base = base * base % p;
      e = e >> 1;
    end
    return acc;
  endfunction

  function automatic longint unsigned wide_mul_mod(longint unsigned x, longint unsigned y,
                                                   longint unsigned m);
    logic [127:0] prod;
    prod = 128'(x) * 128'(y);
    return 64'(prod % 128'(m));
  endfunction

  function automatic longint unsigned garner_value(longint unsigned res[3]);
    longint unsigned mods[4];
    longint unsigned coef[4];
    longint unsigned acc[4];
    longint unsigned p, d, v;
    for (int i = 0; i < 3; i++) mods[i] = lane_prime(i);
    mods[3] = MOD63;
    for (int i = 0; i < 4; i++) begin
      coef[i] = 1;
      acc[i] = 0;
    end
    for (int i = 0; i < 3; i++) begin
      p = mods[i];
      d = (res[i] + p - acc[i]) % p;
      v = d * power_mod(coef[i], p - 2, p) % p;
      for (int j = i + 1; j < 4; j++) begin
        acc[j] = (acc[j] + wide_mul_mod(coef[j], v, mods[j])) % mods[j];
        coef[j] = wide_mul_mod(coef[j], p % mods[j], mods[j]);
      end
    end
    return acc[3];
  endfunction

  function automatic out_t alu_result(in_t it);
    longint unsigned a[3], b[3], r[3], p, mag, m;
    logic [RES_W-1:0] ra[3], rb[3];
    bit neg;
    out_t o;
    ra = '{it.a0, it.a1, it.a2};
    rb = '{it.b0, it.b1, it.b2};
    o = '0;
    for (int l = 0; l < 3; l++) begin
      p = lane_prime(l);
      a[l] = 64'(ra[l]) % p;
      b[l] = 64'(rb[l]) % p;
      r[l] = 0;
    end
    case (it.kind)
      KIND_CONVERT: begin
        neg = it.int_value[63];
        mag = neg ? (~it.int_value + 64'd1) : it.int_value;
        for (int l = 0; l < 3; l++) begin
          m = mag % lane_prime(l);
          r[l] = (neg && m != 0) ? lane_prime(l) - m : m;
        end
      end
      KIND_ADD:
        for (int l = 0; l < 3; l++) r[l] = (a[l] + b[l]) % lane_prime(l);
      KIND_SUB:
        for (int l = 0; l < 3; l++) r[l] = (a[l] + lane_prime(l) - b[l]) % lane_prime(l);
      KIND_MUL:
        for (int l = 0; l < 3; l++) r[l] = a[l] * b[l] % lane_prime(l);
      KIND_DIV:
        for (int l = 0; l < 3; l++)
          r[l] = a[l] * power_mod(b[l], lane_prime(l) - 2, lane_prime(l)) % lane_prime(l);
      KIND_RECON: o.recon_value = 63'(garner_value(a));
      default: ;
    endcase
    o.r0 = 30'(r[0]);
    o.r1 = 30'(r[1]);
    o.r2 = 30'(r[2]);
    return o;
  endfunction

  task automatic send_item(in_t it);
    int gap;
    gap = push_idle_en ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push <= 1'b1;
    in_data_i <= it;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    expected_q.push_back(alu_result(it));
  endtask

  task automatic finish_sends();
    push <= 1'b0;
  endtask

  // pop side: random stall drawn per transfer
  initial begin
    int gap;
    pop = 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = pop_idle_en ? $urandom_range(0, 10) : 0;
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pop <= 1'b1;
      @(posedge clk_i);
      while (empty) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    out_t e;
    if (rst_ni && pop && !empty) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data_o);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (out_data_o.r0 !== e.r0) begin
          $display("%0t: r0 exp %0d got %0d", $time, e.r0, out_data_o.r0);
          errors++;
        end
        if (out_data_o.r1 !== e.r1) begin
          $display("%0t: r1 exp %0d got %0d", $time, e.r1, out_data_o.r1);
          errors++;
        end
        if (out_data_o.r2 !== e.r2) begin
          $display("%0t: r2 exp %0d got %0d", $time, e.r2, out_data_o.r2);
          errors++;
        end
        if (out_data_o.recon_value !== e.recon_value) begin
          $display("%0t: recon exp %0d got %0d", $time, e.recon_value,
                   out_data_o.recon_value);
          errors++;
        end
      end
    end
  end

  function automatic logic [RES_W-1:0] rand_res(int l);
    case ($urandom_range(0, 9))
      0: return 30'($urandom_range(0, 3));
      1: return 30'(lane_prime(l) - 1);
      2: return 30'($urandom_range(32'(lane_prime(l)), 32'h3FFF_FFFF));
      default: return 30'($urandom_range(0, 32'(lane_prime(l) - 1)));
    endcase
  endfunction

  function automatic in_t rand_item(logic [2:0] kind);
    in_t it;
    it.kind = kind;
    it.int_value = {$urandom, $urandom};
    if ($urandom_range(0, 3) == 0) it.int_value = 64'($signed($urandom_range(0, 2000)) - 1000);
    if ($urandom_range(0, 5) == 0)
      it.int_value = 64'(lane_prime($urandom_range(0, 2))) * 64'($urandom_range(0, 1000))
                     * (($urandom_range(0, 1) == 1) ? -64'sd1 : 64'sd1);
    it.a0 = rand_res(0);
    it.a1 = rand_res(1);
    it.a2 = rand_res(2);
    it.b0 = rand_res(0);
    it.b1 = rand_res(1);
    it.b2 = rand_res(2);
    if ($urandom_range(0, 9) == 0) {it.b0, it.b1, it.b2} = '0;
    return it;
  endfunction

  task automatic test_directed();
    in_t it;
    logic signed [63:0] ivals[7];
    ivals = '{64'sh7FFF_FFFF_FFFF_FFFF, 64'sh8000_0000_0000_0001, 64'sh8000_0000_0000_0000,
              64'sd0, -64'sd1, -64'sd1000000007, -64'sd1996488706};
    foreach (ivals[i]) begin
      it = '0;
      it.kind = KIND_CONVERT;
      it.int_value = ivals[i];
      send_item(it);
    end
    for (int k = KIND_ADD; k <= 7; k++) begin
      it = '0;
      it.kind = 3'(k);
      it.a0 = 30'h3FFF_FFFF; it.a1 = 30'h3FFF_FFFF; it.a2 = 30'h3FFF_FFFF;
      it.b0 = 30'h3FFF_FFFF; it.b1 = 30'h3FFF_FFFF; it.b2 = 30'h3FFF_FFFF;
      it.int_value = -64'sd1;
      send_item(it);
      it.a0 = 30'(lane_prime(0) - 1); it.a1 = 30'(lane_prime(1) - 1);
      it.a2 = 30'(lane_prime(2) - 1);
      it.b0 = '0; it.b1 = '0; it.b2 = '0;
      send_item(it);
    end
    it = '0;
    it.kind = KIND_DIV;
    it.a0 = 30'd5; it.a1 = 30'd7; it.a2 = 30'd9;
    it.b0 = 30'd3; it.b1 = 30'd0; it.b2 = 30'(lane_prime(2));
    send_item(it);
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) begin
      if (i % 200 == 0) begin
        push_idle_en = ($urandom_range(0, 2) != 0);
        pop_idle_en = ($urandom_range(0, 2) != 0);
      end
      send_item(rand_item(3'($urandom_range(0, 7))));
    end
    push_idle_en = 1'b0;
    pop_idle_en = 1'b0;
    for (int i = 0; i < 60; i++) send_item(rand_item(3'($urandom_range(0, 5))));
    finish_sends();
  endtask

  initial begin
    push = 1'b0;
    in_data_i = '0;
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(1000);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 20) @(posedge clk_i);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/tpra_pkg.sv
hw/rtl/tpra_reduce.sv
hw/rtl/tpra_modmul.sv
hw/rtl/tpra_front.sv
hw/rtl/tpra_back.sv
hw/rtl/three_prime_residue_alu_core.sv
hw/rtl/tpra_checker.sv
dv/tb_three_prime_residue_alu_core.sv
